// File: sv/one_shot_periodic_timer_bank_defines.svh
// Assertion macros shared by the checker of the timer bank.
`ifndef ONE_SHOT_PERIODIC_TIMER_BANK_DEFINES_SVH
`define ONE_SHOT_PERIODIC_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define OTPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define OTPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank check failed");

`endif

// File: sv/otpt_pkg.sv
// Shared constants, types and helper functions of the timer bank.
`default_nettype none

package otpt_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int COUNT_BITS = 16;
   localparam int NUM_RATES  = 4;

   // Timers covered by the rate map register, two bits each.
   localparam int MAP_TIMERS = 16;
   localparam int ADDR_BITS  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int ENTRY_BITS = 2 * COUNT_BITS;

   // Command codes.
   localparam logic [2:0] CMD_ARM    = 3'd0;
   localparam logic [2:0] CMD_DISARM = 3'd1;
   localparam logic [2:0] CMD_REARM  = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;

   // One result item.
   typedef struct packed {
      logic [3:0]  timer_id;
      logic        was_running;
      logic [15:0] count_out;
      logic        expired;
      logic        error;
      logic        last;
   } rsp_item_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_push_type;

   // Access of the state memory; an entry holds {period, count}.
   typedef struct packed {
      logic                  rd_en;
      addr_type              rd_addr;
      logic                  wr_en;
      addr_type              wr_addr;
      logic [ENTRY_BITS-1:0] wr_data;
   } ram_req_type;

   function automatic addr_type addr_of_index(input logic [3:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[ADDR_BITS-1:0];
   endfunction

   function automatic logic [3:0] id_of_addr(input addr_type a);
      logic [31:0] wide;
      wide = 32'(a);
      return wide[3:0];
   endfunction

   function automatic count_type count_of_field(input logic [15:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[COUNT_BITS-1:0];
   endfunction

   function automatic logic [15:0] field_of_count(input count_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[15:0];
   endfunction

   // Rate group of a timer; timers beyond the map belong to group zero.
   function automatic logic [1:0] group_of(input logic [31:0] map, input addr_type t);
      logic [31:0] shifted;
      shifted = map >> (32'(t) << 1);
      if (32'(t) >= MAP_TIMERS) begin
         return 2'd0;
      end
      return shifted[1:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/otpt_req_if.sv
// Command channel of the timer bank.
`default_nettype none

interface otpt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [3:0]  timer_index;
   logic [15:0] count_value;
   logic [15:0] period_value;
   logic [1:0]  tick_group;

   modport source (output valid, output cmd, output timer_index, output count_value,
                   output period_value, output tick_group, input ready);
   modport sink   (input valid, input cmd, input timer_index, input count_value,
                   input period_value, input tick_group, output ready);
endinterface

`default_nettype wire

// File: sv/otpt_rsp_if.sv
// Result channel of the timer bank.
`default_nettype none

interface otpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  timer_id;
   logic        was_running;
   logic [15:0] count_out;
   logic        expired;
   logic        error;
   logic        last;

   modport source (output valid, output timer_id, output was_running, output count_out,
                   output expired, output error, output last, input ready);
   modport sink   (input valid, input timer_id, input was_running, input count_out,
                   input expired, input error, input last, output ready);
endinterface

`default_nettype wire

// File: sv/otpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module otpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/otpt_out.sv
// Output register of the timer bank: holds one result item until it is taken.
`default_nettype none

module otpt_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire otpt_pkg::rsp_push_type push,
   output logic                       busy,
   otpt_rsp_if.source                 rsp_bus
);

   logic                   valid_ff;
   logic                   valid_in;
   otpt_pkg::rsp_item_type item_ff;

   // A new item may enter in the cycle the held one is taken.
   assign busy = valid_ff && !rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push.valid) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         item_ff <= push.item;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.timer_id    = item_ff.timer_id;
   assign rsp_bus.was_running = item_ff.was_running;
   assign rsp_bus.count_out   = item_ff.count_out;
   assign rsp_bus.expired     = item_ff.expired;
   assign rsp_bus.error       = item_ff.error;
   assign rsp_bus.last        = item_ff.last;

endmodule

`default_nettype wire

// File: sv/otpt_seq.sv
// Command sequencer: reads, modifies and writes back timer entries.
`default_nettype none

module otpt_seq (
   input  wire logic                                clock,
   input  wire logic                                reset,
   otpt_req_if.sink                                 req_bus,
   input  wire logic                                csr_write_enable,
   input  wire logic [31:0]                         csr_write_data,
   input  wire logic                                busy,
   output otpt_pkg::rsp_push_type                   push,
   output otpt_pkg::ram_req_type                    ram_req,
   input  wire logic [otpt_pkg::ENTRY_BITS-1:0]     rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   localparam otpt_pkg::addr_type LAST_TIMER =
      otpt_pkg::ADDR_BITS'(otpt_pkg::NUM_TIMERS - 1);

   state_type            state_ff, state_in;
   logic [31:0]          rate_map_ff;
   logic [2:0]           cmd_ff;
   logic [3:0]           idx_ff;
   otpt_pkg::count_type  cval_ff;
   otpt_pkg::count_type  pval_ff;
   logic [1:0]           grp_ff;
   otpt_pkg::addr_type   walk_ff, walk_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [3:0]           pend_id_ff, pend_id_in;
   logic [otpt_pkg::NUM_TIMERS-1:0] entry_valid_ff;
   logic                 rd_valid_ff;

   logic                 accept;
   otpt_pkg::count_type  cur_count;
   otpt_pkg::count_type  cur_period;
   logic                 running;
   logic                 bad_cmd;
   logic                 tick_match;
   logic                 tick_expire;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // An entry never written since reset reads as a stopped timer.
   assign cur_count  = rd_valid_ff ? rd_data[otpt_pkg::COUNT_BITS-1:0] : '0;
   assign cur_period = rd_valid_ff ? rd_data[otpt_pkg::ENTRY_BITS-1:otpt_pkg::COUNT_BITS]
                                   : '0;
   assign running    = (cur_count != '0);
   assign bad_cmd    = (cmd_ff > otpt_pkg::CMD_TICK)
                    || (32'(idx_ff) >= otpt_pkg::NUM_TIMERS);

   // Tick decision for the timer whose entry is on the read port.
   assign tick_match  = (32'(grp_ff) < otpt_pkg::NUM_RATES)
                     && (otpt_pkg::group_of(rate_map_ff, walk_ff) == grp_ff)
                     && running;
   assign tick_expire = tick_match && (cur_count == otpt_pkg::count_type'(1));

   // Sequencer and memory access.
   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      push          = '0;
      ram_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ram_req.rd_en = 1'b1;
               walk_in       = '0;
               pend_valid_in = 1'b0;
               if (req_bus.cmd == otpt_pkg::CMD_TICK) begin
                  ram_req.rd_addr = '0;
                  state_in        = ST_WALK;
               end else begin
                  ram_req.rd_addr = otpt_pkg::addr_of_index(req_bus.timer_index);
                  state_in        = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (!busy) begin
               push.valid         = 1'b1;
               push.item.timer_id = idx_ff;
               push.item.last     = 1'b1;
               ram_req.wr_addr    = otpt_pkg::addr_of_index(idx_ff);
               state_in           = ST_IDLE;
               if (bad_cmd) begin
                  push.item.error = 1'b1;
               end else begin
                  case (cmd_ff)
                     otpt_pkg::CMD_ARM: begin
                        if (running || (cval_ff == '0)) begin
                           push.item.error = 1'b1;
                        end else begin
                           ram_req.wr_en   = 1'b1;
                           ram_req.wr_data = {pval_ff, cval_ff};
                        end
                     end
                     otpt_pkg::CMD_DISARM: begin
                        push.item.was_running = running;
                        ram_req.wr_en         = 1'b1;
                        ram_req.wr_data       = {cur_period, otpt_pkg::count_type'(0)};
                     end
                     otpt_pkg::CMD_REARM: begin
                        push.item.was_running = running;
                        if (cval_ff == '0) begin
                           push.item.error = 1'b1;
                        end else begin
                           ram_req.wr_en   = 1'b1;
                           ram_req.wr_data = {cur_period, cval_ff};
                        end
                     end
                     default: begin
                        push.item.count_out = otpt_pkg::field_of_count(cur_count);
                     end
                  endcase
               end
            end
         end

         ST_WALK: begin
            // An expiry must hand the earlier one on, so it waits for room.
            if (!(tick_expire && pend_valid_ff && busy)) begin
               if (tick_match) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = walk_ff;
                  ram_req.wr_data = tick_expire
                                  ? {cur_period, cur_period}
                                  : {cur_period, cur_count - otpt_pkg::count_type'(1)};
               end
               if (tick_expire) begin
                  if (pend_valid_ff) begin
                     push.valid         = 1'b1;
                     push.item.timer_id = pend_id_ff;
                     push.item.expired  = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = otpt_pkg::id_of_addr(walk_ff);
               end
               if (walk_ff == LAST_TIMER) begin
                  state_in = ST_FLUSH;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = walk_ff + otpt_pkg::addr_type'(1);
                  walk_in         = walk_ff + otpt_pkg::addr_type'(1);
               end
            end
         end

         ST_FLUSH: begin
            // The final expiry of a tick carries the last flag.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!busy) begin
               push.valid         = 1'b1;
               push.item.timer_id = pend_id_ff;
               push.item.expired  = 1'b1;
               push.item.last     = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rate_map_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_write_enable) begin
            rate_map_ff <= csr_write_data;
         end
         if (ram_req.wr_en) begin
            entry_valid_ff[ram_req.wr_addr] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            rd_valid_ff <= entry_valid_ff[ram_req.rd_addr];
         end
      end
   end

   // Command fields and walk position.
   always_ff @(posedge clock) begin
      walk_ff    <= walk_in;
      pend_id_ff <= pend_id_in;
      if (accept) begin
         cmd_ff  <= req_bus.cmd;
         idx_ff  <= req_bus.timer_index;
         cval_ff <= otpt_pkg::count_of_field(req_bus.count_value);
         pval_ff <= otpt_pkg::count_of_field(req_bus.period_value);
         grp_ff  <= req_bus.tick_group;
      end
   end

endmodule

`default_nettype wire

// File: sv/one_shot_periodic_timer_bank.sv
// Bank of one-shot and periodic down-counting timers: top level.
//
// Commands enter on req_bus (valid/ready); results leave on rsp_bus.
// The rate map register is written through csr_write_enable/csr_write_data.
// Arm, disarm, rearm and read, and any invalid command (flagged error), each give
// one result, flagged last, pushed once the entry is read and the output register
// has room, then offered from that register; the next command is taken after the push.
// A tick walks the whole bank, one timer per cycle unless an expiry stalls, through
// the single read port of the state memory, and reports each expiry of its rate
// group in index order, the last one flagged; a flush state after the walk hands
// on that last expiry, and the tick gives no result if nothing expires.
// A stalled receiver holds its result in the output register; the walk
// pauses only when a second expiry finds that register still full.
// Reset clears the rate map and marks every entry unwritten, so all timers
// read as stopped with zero period at once; no clearing pass is needed.
`default_nettype none

module one_shot_periodic_timer_bank (
   input  wire logic  clock,
   input  wire logic  reset,
   otpt_req_if.sink   req_bus,
   otpt_rsp_if.source rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   otpt_pkg::rsp_push_type             push;
   otpt_pkg::ram_req_type              ram_req;
   logic                               busy;
   logic [otpt_pkg::ENTRY_BITS-1:0]    rd_data;

   // Timer state memory: {period, count} per timer.
   otpt_ram #(
      .WIDTH (otpt_pkg::ENTRY_BITS),
      .DEPTH (otpt_pkg::NUM_TIMERS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // Command sequencer.
   otpt_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .push             (push),
      .ram_req          (ram_req),
      .rd_data          (rd_data)
   );

   // Result output register.
   otpt_out u_out (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .busy    (busy),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// File: sv/otpt_checker.sv
// Port-level checks of the timer bank and their binding to the top level.
`default_nettype none
`include "one_shot_periodic_timer_bank_defines.svh"

module otpt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [2:0]  req_cmd,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_was_running,
   input wire logic [15:0] rsp_count_out,
   input wire logic        rsp_expired,
   input wire logic        rsp_error,
   input wire logic        rsp_last
);

   // A stalled result item stays offered.
   `OTPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // An expiry report carries no command status.
   `OTPT_ASSERT_NOW(a_expiry_clean, clock, reset, rsp_valid && rsp_expired,
                    !rsp_error && !rsp_was_running && (rsp_count_out == 16'd0))

   // Every non-tick result is the only one of its command.
   `OTPT_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && !rsp_expired, rsp_last)

   // A command other than a tick gives no result in the cycle after it is taken.
   `OTPT_ASSERT_NEXT(a_no_early_rsp, clock, reset,
                     req_valid && req_ready && (req_cmd != otpt_pkg::CMD_TICK) && !rsp_valid,
                     !rsp_valid)

endmodule

bind one_shot_periodic_timer_bank otpt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_cmd         (req_bus.cmd),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_was_running (rsp_bus.was_running),
   .rsp_count_out   (rsp_bus.count_out),
   .rsp_expired     (rsp_bus.expired),
   .rsp_error       (rsp_bus.error),
   .rsp_last        (rsp_bus.last)
);

`default_nettype wire
